@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication
`define RBE_ASSERT_IMP(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define RBE_ASSERT_NXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error(msg);
`else
`define RBE_ASSERT_IMP(lbl, ant, cons, msg)
`define RBE_ASSERT_NXT(lbl, ant, cons, msg)
`endif
`endif

@@ hdl/rbe_pkg.sv @@
// ----------------------------------------------------------------------------
// rbe_pkg
// Codes, constants and controller/datapath interface types of the blitter.
// ----------------------------------------------------------------------------
package rbe_pkg;

  localparam int unsigned MEM_BYTES_DEF = 65536;
  localparam int unsigned PARAM_COUNT   = 7;
  localparam int unsigned PIDX_W        = $clog2(PARAM_COUNT);
  localparam logic [63:0] PAL_BYTES     = 64'd768;
  localparam logic [31:0] BPP_8         = 32'd8;
  localparam logic [31:0] BPP_24        = 32'd24;
  localparam logic [31:0] ST_OK         = 32'd0;
  localparam logic [31:0] ST_ERR        = 32'd1;

  // Transaction opcodes
  localparam logic [2:0] OP_REG_RD = 3'd0;
  localparam logic [2:0] OP_REG_WR = 3'd1;
  localparam logic [2:0] OP_MEM_RD = 3'd2;
  localparam logic [2:0] OP_MEM_WR = 3'd3;
  localparam logic [2:0] OP_TICK   = 3'd4;

  // Command register codes
  localparam logic [31:0] CMD_INIT       = 32'd0;
  localparam logic [31:0] CMD_FRAMECOUNT = 32'd1;
  localparam logic [31:0] CMD_SET_BUFFER = 32'd2;
  localparam logic [31:0] CMD_SET_PAL    = 32'd3;
  localparam logic [31:0] CMD_SET_SRC    = 32'd4;
  localparam logic [31:0] CMD_SET_DST    = 32'd5;
  localparam logic [31:0] CMD_ROW_BLIT   = 32'd6;
  localparam logic [31:0] CMD_TILE_BLIT  = 32'd7;
  localparam logic [31:0] CMD_MASK_BLIT  = 32'd8;

  typedef enum logic [2:0] {
    CLS_SIMPLE, CLS_SRC, CLS_ROW, CLS_TILE, CLS_MASK
  } cls_t;

  typedef enum logic [1:0] {CHK_SRC, CHK_DST, CHK_TILE, CHK_MASK} chk_sel_t;
  typedef enum logic [1:0] {MUL_CHK, MUL_S, MUL_D, MUL_M} mul_sel_t;

  typedef enum logic [4:0] {
    S_IDLE, S_MRD, S_CMD, S_CHK1A, S_CHK1B, S_CHK2A, S_CHK2B, S_SETUP,
    S_F0, S_F1, S_F2, S_F3, S_START, S_ROW, S_MASK_RD, S_MASK_LD, S_BIT,
    S_WR, S_ROW_END, S_OK, S_ERR
  } state_t;

  typedef struct packed {
    logic     accept;
    logic     mrd_done;
    logic     simple_exec;
    logic     set_src;
    logic     status_ok;
    logic     status_err;
    logic     setup;
    logic     add_s;
    logic     add_d;
    logic     add_m;
    logic     row_start;
    logic     mask_rd;
    logic     mask_ld;
    logic     byte_rd;
    logic     byte_wr;
    logic     col_adv;
    logic     row_end;
    chk_sel_t chk_sel;
    mul_sel_t mul_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic in_is_mrd;
    logic in_is_cmd;
    cls_t cls;
    logic chk_bad;
    logic tile_zero;
    logic flip;
    logic run_empty;
    logic masked;
    logic bit0;
    logic col_last;
    logic mask_edge;
    logic row_stop;
  } ctrl_stat_t;

endpackage

@@ hdl/rbe_ctrl.sv @@
// ----------------------------------------------------------------------------
// rbe_ctrl
// Sequencer: accepts transactions, runs commands, walks blits byte by byte.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module rbe_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rbe_pkg::ctrl_stat_t stat,
  output rbe_pkg::ctrl_cmd_t  cmd
);
  import rbe_pkg::*;

  state_t   state_r, state_nxt;
  chk_sel_t first_sel;
  logic     skip_bit;

  // Pick the first bounds check from the command class
  always_comb begin
    case (stat.cls)
      CLS_SRC:  first_sel = CHK_SRC;
      CLS_TILE: first_sel = CHK_TILE;
      CLS_MASK: first_sel = CHK_MASK;
      default:  first_sel = CHK_DST;
    endcase
  end

  assign skip_bit = stat.masked && !stat.bit0;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          if (stat.in_is_mrd) state_nxt = S_MRD;
          else if (stat.in_is_cmd) state_nxt = S_CMD;
        end
      end
      S_MRD:   state_nxt = S_IDLE;
      S_CMD:   state_nxt = (stat.cls == CLS_SIMPLE) ? S_IDLE : S_CHK1A;
      S_CHK1A: state_nxt = S_CHK1B;
      S_CHK1B: begin
        if (stat.chk_bad) state_nxt = S_ERR;
        else if (stat.cls == CLS_SRC) state_nxt = S_OK;
        else if (stat.cls == CLS_TILE && stat.tile_zero) state_nxt = S_ERR;
        else if (stat.cls == CLS_MASK) state_nxt = S_CHK2A;
        else state_nxt = S_SETUP;
      end
      S_CHK2A: state_nxt = S_CHK2B;
      S_CHK2B: state_nxt = stat.chk_bad ? S_ERR : S_SETUP;
      S_SETUP: state_nxt = stat.flip ? S_F0 : S_START;
      S_F0:    state_nxt = S_F1;
      S_F1:    state_nxt = S_F2;
      S_F2:    state_nxt = S_F3;
      S_F3:    state_nxt = S_START;
      S_START: state_nxt = stat.run_empty ? S_OK : S_ROW;
      S_ROW:   state_nxt = stat.masked ? S_MASK_RD : S_BIT;
      S_MASK_RD: state_nxt = S_MASK_LD;
      S_MASK_LD: state_nxt = S_BIT;
      S_BIT: begin
        if (!skip_bit) state_nxt = S_WR;
        else if (stat.col_last) state_nxt = S_ROW_END;
        else if (stat.mask_edge) state_nxt = S_MASK_RD;
        else state_nxt = S_BIT;
      end
      S_WR: begin
        if (stat.col_last) state_nxt = S_ROW_END;
        else if (stat.masked && stat.mask_edge) state_nxt = S_MASK_RD;
        else state_nxt = S_BIT;
      end
      S_ROW_END: state_nxt = stat.row_stop ? S_OK : S_ROW;
      S_OK:    state_nxt = S_IDLE;
      S_ERR:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Drive commands
  always_comb begin
    cmd         = '0;
    cmd.chk_sel = CHK_DST;
    cmd.mul_sel = MUL_CHK;
    in_ready    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready   = stat.out_free;
        cmd.accept = in_valid && stat.out_free;
      end
      S_MRD:   cmd.mrd_done = 1'b1;
      S_CMD:   cmd.simple_exec = (stat.cls == CLS_SIMPLE);
      S_CHK1A: cmd.chk_sel = first_sel;
      S_CHK1B: begin
        cmd.chk_sel = first_sel;
        cmd.set_src = (stat.cls == CLS_SRC) && !stat.chk_bad;
      end
      S_CHK2A, S_CHK2B: cmd.chk_sel = CHK_DST;
      S_SETUP: cmd.setup = 1'b1;
      S_F0:    cmd.mul_sel = MUL_S;
      S_F1: begin
        cmd.mul_sel = MUL_D;
        cmd.add_s   = 1'b1;
      end
      S_F2: begin
        cmd.mul_sel = MUL_M;
        cmd.add_d   = 1'b1;
      end
      S_F3:      cmd.add_m = 1'b1;
      S_ROW:     cmd.row_start = 1'b1;
      S_MASK_RD: cmd.mask_rd = 1'b1;
      S_MASK_LD: cmd.mask_ld = 1'b1;
      S_BIT: begin
        cmd.col_adv = skip_bit;
        cmd.byte_rd = !skip_bit;
      end
      S_WR: begin
        cmd.byte_wr = 1'b1;
        cmd.col_adv = 1'b1;
      end
      S_ROW_END: cmd.row_end = 1'b1;
      S_OK:      cmd.status_ok = 1'b1;
      S_ERR:     cmd.status_err = 1'b1;
      default: ;
    endcase
  end

  `RBE_ASSERT_NXT(a_cmd_start, in_valid && in_ready && stat.in_is_cmd, state_r == S_CMD, "command write did not start execution")
  `RBE_ASSERT_IMP(a_wr_after_rd, state_r == S_WR, $past(state_r) == S_BIT, "byte write without a preceding read")
  `RBE_ASSERT_NXT(a_mask_to_bit, state_r == S_MASK_LD, state_r == S_BIT, "mask load not followed by bit step")

endmodule

@@ hdl/rbe_datapath.sv @@
// ----------------------------------------------------------------------------
// rbe_datapath
// Register file, byte memory, bounds checker, multiplier and blit pointers.
// ----------------------------------------------------------------------------
module rbe_datapath #(
  parameter int unsigned MEM_BYTES = rbe_pkg::MEM_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rbe_pkg::ctrl_cmd_t  cmd,
  output rbe_pkg::ctrl_stat_t stat,
  input  logic [2:0]         in_opcode,
  input  logic [15:0]        in_address,
  input  logic [31:0]        in_write_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_read_data
);
  import rbe_pkg::*;

  localparam int unsigned AW    = $clog2(MEM_BYTES);
  localparam logic [63:0] MEM64 = 64'(MEM_BYTES);

  // Architectural registers
  logic [31:0] param_r [PARAM_COUNT];
  logic [31:0] command_r, frame_r;
  logic        init_r;
  logic [31:0] src_base_r, src_stride_r, src_w_r, src_h_r;
  logic [31:0] dst_base_r, dst_stride_r;
  logic        out_valid_r;
  logic [31:0] out_data_r;

  // Blit working registers
  logic [31:0] s_r, d_r, m_r, ss_r, ds_r, ms_r, w_r, h_r, sw_r, sh_r, first_r;
  logic [31:0] rowc_r, trow_r, jc_r, kc_r, quiet_r, period_r;
  logic        periodic_r, ch_r;
  logic [7:0]  bits_r;
  cls_t        mode_r;
  logic [63:0] prod_r;

  // Memory
  logic [7:0]  mem [MEM_BYTES];
  logic [7:0]  rd_a_r, rd_b_r;
  logic [AW-1:0] ra_a, ra_b, wa, in_idx;
  logic [7:0]  wd;
  logic        we;

  logic [31:0] in_addr32, reg_rd, p0, p1, p2, p3;
  logic [PIDX_W-1:0] pidx;
  logic        addr_is_cmd, addr_is_par;
  cls_t        cls;

  logic [31:0] chk_base, chk_stride, chk_w, chk_h, mag, mw, mul_a, mul_b;
  logic [63:0] room;
  logic        chk_bad;

  logic [31:0] src_addr, dst_addr, mask_addr, jc_nxt, quiet_nxt;

  assign p0 = param_r[0];
  assign p1 = param_r[1];
  assign p2 = param_r[2];
  assign p3 = param_r[3];

  // Decode the transaction address
  assign in_addr32   = 32'(in_address);
  assign in_idx      = in_addr32[AW-1:0];
  assign addr_is_cmd = (in_address == 16'd0);
  assign addr_is_par = !addr_is_cmd && (in_address <= 16'(PARAM_COUNT));
  assign pidx        = PIDX_W'(in_address - 16'd1);

  always_comb begin
    if (addr_is_cmd) reg_rd = command_r;
    else if (addr_is_par) reg_rd = param_r[pidx];
    else reg_rd = '1;
  end

  // Classify the command register
  always_comb begin
    case (command_r)
      CMD_SET_SRC:   cls = CLS_SRC;
      CMD_ROW_BLIT:  cls = CLS_ROW;
      CMD_TILE_BLIT: cls = CLS_TILE;
      CMD_MASK_BLIT: cls = CLS_MASK;
      default:       cls = CLS_SIMPLE;
    endcase
  end

  // Select the region under check
  assign mw = (src_w_r + 32'd7) >> 3;
  always_comb begin
    case (cmd.chk_sel)
      CHK_SRC: begin
        chk_base = p0; chk_stride = p1; chk_w = p2; chk_h = p3;
      end
      CHK_TILE: begin
        chk_base = dst_base_r; chk_stride = dst_stride_r; chk_w = p1; chk_h = p2;
      end
      CHK_MASK: begin
        chk_base = p1; chk_stride = p2; chk_w = mw; chk_h = src_h_r;
      end
      default: begin
        chk_base = dst_base_r; chk_stride = dst_stride_r;
        chk_w = src_w_r; chk_h = src_h_r;
      end
    endcase
  end
  assign mag = chk_stride[31] ? (32'd0 - chk_stride) : chk_stride;

  // Select multiplier operands
  always_comb begin
    case (cmd.mul_sel)
      MUL_S: begin
        mul_a = ((mode_r == CLS_TILE) ? sh_r : h_r) - 32'd1;
        mul_b = ss_r;
      end
      MUL_D: begin
        mul_a = h_r - 32'd1; mul_b = ds_r;
      end
      MUL_M: begin
        mul_a = h_r - 32'd1; mul_b = ms_r;
      end
      default: begin
        mul_a = chk_h - 32'd1; mul_b = mag;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= {32'd0, mul_a} * {32'd0, mul_b};
  end

  // Compare the registered span against the room left in memory
  assign room = MEM64 - {32'd0, chk_base};
  always_comb begin
    if (chk_w == 32'd0 || chk_h == 32'd0) chk_bad = 1'b0;
    else if ({32'd0, chk_base} > MEM64) chk_bad = 1'b1;
    else if ({32'd0, chk_w} > room) chk_bad = 1'b1;
    else if (chk_stride[31]) chk_bad = prod_r > {32'd0, chk_base};
    else chk_bad = (prod_r + {32'd0, chk_w}) > room;
  end

  // Form blit addresses
  assign src_addr  = s_r + ((mode_r == CLS_TILE) ? kc_r : jc_r);
  assign dst_addr  = d_r + jc_r;
  assign mask_addr = m_r + (jc_r >> 3);
  assign jc_nxt    = jc_r + 32'd1;
  assign quiet_nxt = ch_r ? 32'd0 : (quiet_r + 32'd1);

  // Route memory ports
  always_comb begin
    if (cmd.mask_rd) ra_a = mask_addr[AW-1:0];
    else if (cmd.byte_rd) ra_a = src_addr[AW-1:0];
    else ra_a = in_idx;
    ra_b = dst_addr[AW-1:0];
    if (cmd.byte_wr) begin
      we = 1'b1; wa = dst_addr[AW-1:0]; wd = rd_a_r;
    end else begin
      we = cmd.accept && (in_opcode == OP_MEM_WR);
      wa = in_idx;
      wd = in_write_data[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_a_r <= mem[ra_a];
    rd_b_r <= mem[ra_b];
  end

  // Update registers, commands and result slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PARAM_COUNT; i++) param_r[i] <= '0;
      command_r <= '0; frame_r <= '0; init_r <= 1'b0;
      src_base_r <= '0; src_stride_r <= '0; src_w_r <= '0; src_h_r <= '0;
      dst_base_r <= '0; dst_stride_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (cmd.accept) begin
        out_valid_r <= (in_opcode != OP_MEM_RD);
        out_data_r  <= (in_opcode == OP_REG_RD) ? reg_rd : 32'd0;
        case (in_opcode)
          OP_REG_WR: begin
            if (addr_is_cmd) command_r <= in_write_data;
            else if (addr_is_par) param_r[pidx] <= in_write_data;
          end
          OP_TICK: frame_r <= frame_r + 32'd1;
          default: ;
        endcase
      end
      if (cmd.mrd_done) begin
        out_valid_r <= 1'b1;
        out_data_r  <= {24'd0, rd_a_r};
      end
      if (cmd.simple_exec) begin
        case (command_r)
          CMD_INIT: begin
            if (init_r || (p0 != BPP_8 && p0 != BPP_24)) begin
              param_r[0] <= ST_ERR;
            end else begin
              init_r     <= 1'b1;
              param_r[0] <= ST_OK;
            end
          end
          CMD_FRAMECOUNT: begin
            param_r[1] <= frame_r;
            param_r[0] <= ST_OK;
          end
          CMD_SET_BUFFER: param_r[0] <= ({32'd0, p0} >= MEM64) ? ST_ERR : ST_OK;
          CMD_SET_PAL: param_r[0] <= (({32'd0, p0} + PAL_BYTES) >= MEM64) ? ST_ERR : ST_OK;
          CMD_SET_DST: begin
            dst_base_r   <= p0;
            dst_stride_r <= p1;
            param_r[0]   <= ST_OK;
          end
          default: param_r[0] <= ST_ERR;
        endcase
      end
      if (cmd.set_src) begin
        src_base_r <= p0; src_stride_r <= p1; src_w_r <= p2; src_h_r <= p3;
      end
      if (cmd.status_ok) param_r[0] <= ST_OK;
      if (cmd.status_err) param_r[0] <= ST_ERR;
    end
  end

  // Advance blit pointers and counters
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      s_r <= src_base_r; ss_r <= src_stride_r; first_r <= src_base_r;
      d_r <= dst_base_r; ds_r <= dst_stride_r;
      m_r <= p1; ms_r <= p2;
      w_r <= (cls == CLS_TILE) ? p1 : src_w_r;
      h_r <= (cls == CLS_TILE) ? p2 : src_h_r;
      sw_r <= src_w_r; sh_r <= src_h_r;
      mode_r <= cls;
      case (cls)
        CLS_TILE: periodic_r <= (dst_stride_r == 32'd0);
        CLS_MASK: periodic_r <= (src_stride_r == 32'd0) && (dst_stride_r == 32'd0)
                                && (p2 == 32'd0);
        default:  periodic_r <= (src_stride_r == 32'd0) && (dst_stride_r == 32'd0);
      endcase
      period_r <= (cls == CLS_TILE && src_stride_r != 32'd0) ? src_h_r : 32'd1;
      quiet_r <= '0; rowc_r <= '0; trow_r <= '0;
    end
    if (cmd.add_s) begin
      s_r     <= s_r + prod_r[31:0];
      first_r <= s_r + prod_r[31:0];
    end
    if (cmd.add_d) d_r <= d_r + prod_r[31:0];
    if (cmd.add_m) begin
      m_r  <= m_r + prod_r[31:0];
      ss_r <= 32'd0 - ss_r;
      ds_r <= 32'd0 - ds_r;
      ms_r <= 32'd0 - ms_r;
    end
    if (cmd.row_start) begin
      jc_r <= '0; kc_r <= '0; ch_r <= 1'b0;
    end
    if (cmd.mask_ld) bits_r <= rd_a_r;
    if (cmd.byte_wr) ch_r <= ch_r | (rd_a_r != rd_b_r);
    if (cmd.col_adv) begin
      bits_r <= bits_r >> 1;
      jc_r   <= jc_nxt;
      kc_r   <= (kc_r + 32'd1 == sw_r) ? 32'd0 : (kc_r + 32'd1);
    end
    if (cmd.row_end) begin
      quiet_r <= quiet_nxt;
      rowc_r  <= rowc_r + 32'd1;
      d_r     <= d_r + ds_r;
      m_r     <= m_r + ms_r;
      if (mode_r == CLS_TILE && trow_r + 32'd1 == sh_r) begin
        s_r    <= first_r;
        trow_r <= '0;
      end else begin
        s_r    <= s_r + ss_r;
        trow_r <= trow_r + 32'd1;
      end
    end
  end

  // Report status
  always_comb begin
    stat.out_free  = !out_valid_r || out_ready;
    stat.in_is_mrd = (in_opcode == OP_MEM_RD);
    stat.in_is_cmd = (in_opcode == OP_REG_WR) && addr_is_cmd;
    stat.cls       = cls;
    stat.chk_bad   = chk_bad;
    stat.tile_zero = (src_w_r == 32'd0) || (src_h_r == 32'd0);
    stat.flip      = (p0 != 32'd0);
    stat.run_empty = (w_r == 32'd0) || (h_r == 32'd0);
    stat.masked    = (mode_r == CLS_MASK);
    stat.bit0      = bits_r[0];
    stat.col_last  = (jc_nxt == w_r);
    stat.mask_edge = (jc_nxt[2:0] == 3'd0);
    stat.row_stop  = (periodic_r && quiet_nxt >= period_r) || (rowc_r + 32'd1 == h_r);
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

endmodule

@@ hdl/register_blitter_engine_unit.sv @@
// ----------------------------------------------------------------------------
// register_blitter_engine_unit
// Register-driven blitter with a private byte memory.
// ----------------------------------------------------------------------------
//  channel | ports                                      | direction
//  --------+--------------------------------------------+----------
//  in      | in_valid in_ready in_opcode in_address     | to block
//          | in_write_data                              |
//  out     | out_valid out_ready out_read_data          | from block
//
// Register accesses, memory writes and frame ticks are answered from the
// output register; a memory read also waits for the registered read port.
// A command write returns its transaction at once; the next transaction waits
// until the command finishes: a simple command runs in the command state, set
// source runs a bounds check, then status. A blit runs its checks (a second
// one for the masked copy), setup, a bottom-up pointer flip when requested and
// a start step, then per copied byte a read, then a write through the single
// write port; a masked-off byte takes only a bit step, a mask byte is fetched,
// then loaded, and each row has a start and an end step, then a status step.
// Reset (synchronous, rst_n low) clears registers and status; memory is not
// cleared. A stalled result holds the output register and blocks new input.
module register_blitter_engine_unit #(
  parameter int unsigned MEM_BYTES = rbe_pkg::MEM_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_opcode,
  input  logic [15:0] in_address,
  input  logic [31:0] in_write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_read_data
);
  import rbe_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  // Sequence transactions and commands
  rbe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold state and memory
  rbe_datapath #(.MEM_BYTES(MEM_BYTES)) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_opcode     (in_opcode),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_read_data (out_read_data)
  );

endmodule
